// ===== design/swsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine-window smoothing FIR: shared definitions
// Widths, the fixed tap weights, and the item types passed between the
// accept side, the job queue and the multiply-accumulate side.
// ----------------------------------------------------------------------------
package swsf_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 17;
   localparam int FRAC_W    = 16;
   localparam int TAPS      = 9;
   localparam int LEAD_PAD  = (TAPS - 1) / 2;
   localparam int TRAIL_PAD = TAPS - 1 - LEAD_PAD;

   // seen holds 0 .. TAPS-1, the edge offset 0 .. TRAIL_PAD.
   localparam int SEEN_W = $clog2(TAPS);
   localparam int EDGE_W = $clog2(TRAIL_PAD + 1);
   // Signed window offset before clamping, range -TRAIL_PAD .. TAPS-1.
   localparam int IDX_W  = SEEN_W + 1;

   // A 24 x 18 signed product; nine of them cannot overflow this width.
   localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
   localparam int ACC_W      = PROD_W;
   localparam int GROUP_SIZE = 3;
   localparam int GROUPS     = TAPS / GROUP_SIZE;

   localparam int JOB_DEPTH = 2;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Unsigned Q1.16 weights: sin(pi*i/8) normalized to a sum of exactly 1.0,
   // rounded per tap, with the rounding residue folded into the center tap.
   localparam logic [COEF_W-1:0] TAP_WEIGHT [TAPS] = '{
      17'd0, 17'd4989, 17'd9218, 17'd12044, 17'd13034,
      17'd12044, 17'd9218, 17'd4989, 17'd0
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       is_last_res;
   } rsp_type;

   // One unit of work for the back side: a window snapshot (newest at 0),
   // the number of earlier samples of the curve, and the first edge offset.
   typedef struct packed {
      logic [TAPS-1:0][SAMPLE_W-1:0] win;
      logic [SEEN_W-1:0]             seen;
      logic [EDGE_W-1:0]             e_first;
      logic                          last;
   } job_type;

endpackage

// ===== design/swsf_front.sv =====
// ----------------------------------------------------------------------------
// Sine-window smoothing FIR: accept side
// Takes samples, keeps the sample window and the per-curve count, and turns
// each sample that completes outputs into a job for the back side.
// ----------------------------------------------------------------------------
module swsf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  swsf_pkg::req_type req_item,
   input  logic              job_full,
   output logic              job_push,
   output swsf_pkg::job_type job_item
);
   import swsf_pkg::*;

   logic [TAPS-1:0][SAMPLE_W-1:0] win_ff, win_in;
   logic [SEEN_W-1:0]             seen_ff, seen_in;
   logic                          accept;
   logic                          reaches_center;

   assign full   = job_full;
   assign accept = push && !full;

   always_comb begin
      win_in         = {win_ff[TAPS-2:0], req_item.sample};
      reaches_center = seen_ff >= SEEN_W'(TRAIL_PAD);

      if (req_item.is_last) begin
         seen_in = '0;
      end else if (seen_ff == SEEN_W'(TAPS - 1)) begin
         seen_in = seen_ff;
      end else begin
         seen_in = seen_ff + SEEN_W'(1);
      end

      job_item.win  = win_in;
      job_item.seen = seen_ff;
      job_item.last = req_item.is_last;
      // A short curve flushes from its oldest sample.
      if (req_item.is_last && !reaches_center) begin
         job_item.e_first = seen_ff[EDGE_W-1:0];
      end else begin
         job_item.e_first = EDGE_W'(TRAIL_PAD);
      end

      job_push = accept && (req_item.is_last || reaches_center);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
   end

   // Entries older than the current curve are never selected downstream.
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// ===== design/swsf_job_fifo.sv =====
// ----------------------------------------------------------------------------
// Sine-window smoothing FIR: job queue
// A short first-word-fall-through queue that lets the accept side and the
// filter side stall independently.
// ----------------------------------------------------------------------------
module swsf_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_push,
   input  swsf_pkg::job_type job_in,
   output logic              job_full,
   input  logic              job_pop,
   output swsf_pkg::job_type job_out,
   output logic              job_empty
);
   import swsf_pkg::*;

   job_type              mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff;
   logic [JOB_PTR_W-1:0] rd_ptr_ff;
   logic [JOB_CNT_W-1:0] cnt_ff;

   assign job_full  = cnt_ff == JOB_CNT_W'(JOB_DEPTH);
   assign job_empty = cnt_ff == '0;
   assign job_out   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (job_push) begin
            wr_ptr_ff <= wr_ptr_ff + JOB_PTR_W'(1);
         end
         if (job_pop) begin
            rd_ptr_ff <= rd_ptr_ff + JOB_PTR_W'(1);
         end
         if (job_push && !job_pop) begin
            cnt_ff <= cnt_ff + JOB_CNT_W'(1);
         end else if (!job_push && job_pop) begin
            cnt_ff <= cnt_ff - JOB_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ===== design/swsf_back.sv =====
// ----------------------------------------------------------------------------
// Sine-window smoothing FIR: filter side
// Walks each job's edge offsets, one dot product per cycle while the result
// queue has room, via a three-stage multiply, partial-sum and round pipeline.
// ----------------------------------------------------------------------------
module swsf_back (
   input  logic              clock,
   input  logic              reset,
   input  swsf_pkg::job_type job_item,
   input  logic              job_empty,
   output logic              job_pop,
   output swsf_pkg::rsp_type rsp_item,
   output logic              empty,
   input  logic              pop
);
   import swsf_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      (ACC_W'(1) << (SAMPLE_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) << (SAMPLE_W - 1));

   // Job sequencer.
   job_type           job_ff;
   logic              busy_ff;
   logic [EDGE_W-1:0] e_ff;
   logic              issue;
   logic              job_done;
   logic              credit_ok;

   // Operand selection and pipeline.
   logic signed [IDX_W-1:0]    idx [TAPS];
   logic [SEEN_W-1:0]          sel [TAPS];
   logic signed [SAMPLE_W-1:0] operand [TAPS];
   logic signed [PROD_W-1:0]   prod_in [TAPS];
   logic signed [PROD_W-1:0]   prod_ff [TAPS];
   logic                       v1_ff;
   logic                       last1_ff;
   logic signed [ACC_W-1:0]    part_in [GROUPS];
   logic signed [ACC_W-1:0]    part_ff [GROUPS];
   logic                       v2_ff;
   logic                       last2_ff;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    rounded;
   logic signed [SAMPLE_W-1:0] sat;
   rsp_type                    rsp_in;

   // Result queue.
   rsp_type              rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_CNT_W-1:0] cnt_ff;
   logic [RSP_CNT_W-1:0] committed;
   logic                 rsp_pop;

   // An item is issued only if the queue has room for it once everything
   // already in the pipeline has landed.
   always_comb begin
      committed = cnt_ff + RSP_CNT_W'(v1_ff) + RSP_CNT_W'(v2_ff);
      credit_ok = committed < RSP_CNT_W'(RSP_DEPTH);
      issue     = busy_ff && credit_ok;
      job_done  = issue && (!job_ff.last || e_ff == '0);
      job_pop   = !job_empty && (!busy_ff || job_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (job_pop) begin
         busy_ff <= 1'b1;
      end else if (job_done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_item;
         e_ff   <= job_item.e_first;
      end else if (issue) begin
         e_ff <= e_ff - EDGE_W'(1);
      end
   end

   // Tap j reads sample e + LEAD_PAD - j, clamped to the samples of this
   // curve: below zero repeats the newest sample, beyond seen the oldest.
   always_comb begin
      for (int j = 0; j < TAPS; j++) begin
         idx[j] = $signed({{(IDX_W - EDGE_W){1'b0}}, e_ff}) + $signed(IDX_W'(LEAD_PAD))
                  - $signed(IDX_W'(j));
         if (idx[j][IDX_W-1]) begin
            sel[j] = '0;
         end else if (idx[j][SEEN_W-1:0] > job_ff.seen) begin
            sel[j] = job_ff.seen;
         end else begin
            sel[j] = idx[j][SEEN_W-1:0];
         end
         operand[j] = $signed(job_ff.win[sel[j]]);
         prod_in[j] = PROD_W'(operand[j] * $signed({1'b0, TAP_WEIGHT[j]}));
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = prod_ff[g * GROUP_SIZE] + prod_ff[g * GROUP_SIZE + 1]
                      + prod_ff[g * GROUP_SIZE + 2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         prod_ff  <= prod_in;
         last1_ff <= job_ff.last && (e_ff == '0);
      end
      if (v1_ff) begin
         part_ff  <= part_in;
         last2_ff <= last1_ff;
      end
   end

   // Round to nearest with ties toward plus infinity, then saturate.
   always_comb begin
      acc     = part_ff[0] + part_ff[1] + part_ff[2];
      rounded = (acc + ROUND_HALF) >>> FRAC_W;
      if (rounded > SAT_MAX) begin
         sat = SAMPLE_W'(SAT_MAX);
      end else if (rounded < SAT_MIN) begin
         sat = SAMPLE_W'(SAT_MIN);
      end else begin
         sat = SAMPLE_W'(rounded);
      end
      rsp_in.smoothed    = sat;
      rsp_in.is_last_res = last2_ff;
   end

   assign empty    = cnt_ff == '0;
   assign rsp_pop  = pop && !empty;
   assign rsp_item = rsp_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (v2_ff) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         if (v2_ff && !rsp_pop) begin
            cnt_ff <= cnt_ff + RSP_CNT_W'(1);
         end else if (!v2_ff && rsp_pop) begin
            cnt_ff <= cnt_ff - RSP_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         rsp_mem_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ===== design/sine_window_smoothing_fir.sv =====
// ----------------------------------------------------------------------------
// Sine-window smoothing FIR
// Nine-tap sine-window smoothing filter with edge replication at both ends
// of each curve; the last sample of a curve flushes the pending outputs.
// ----------------------------------------------------------------------------
// A sample crosses the job queue and job, product and partial-sum registers.
// Throughput: one sample per cycle while the job queue has room; a last sample
// keeps the shared multiply-accumulate unit busy for min(seen, 4) + 1 results.
// Reset clears the curve count, both queues and the pipeline valid bits;
// the sample window is not cleared, as stale entries are never selected.
module sine_window_smoothing_fir (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  swsf_pkg::req_type req_item,
   output logic              empty,
   input  logic              pop,
   output swsf_pkg::rsp_type rsp_item
);
   import swsf_pkg::*;

   job_type job_in;
   job_type job_out;
   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;

   swsf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .job_full (job_full),
      .job_push (job_push),
      .job_item (job_in)
   );

   swsf_job_fifo u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .job_push  (job_push),
      .job_in    (job_in),
      .job_full  (job_full),
      .job_pop   (job_pop),
      .job_out   (job_out),
      .job_empty (job_empty)
   );

   swsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_item  (job_out),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_item  (rsp_item),
      .empty     (empty),
      .pop       (pop)
   );

   a_no_job_overflow : assert property (@(posedge clock) disable iff (reset)
      !(job_push && job_full))
      else $error("job queue written while full");

   a_no_job_underflow : assert property (@(posedge clock) disable iff (reset)
      !(job_pop && job_empty))
      else $error("job queue read while empty");

   a_flush_within_curve : assert property (@(posedge clock) disable iff (reset)
      (job_push && job_in.last) |-> (job_in.e_first <= job_in.seen ||
                                     job_in.e_first == EDGE_W'(TRAIL_PAD)))
      else $error("flush starts beyond the samples of the curve");

   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result queue not empty after reset");

endmodule

// ===== sim/sine_window_smoothing_fir_tb.sv =====
// ----------------------------------------------------------------------------
// Sine-window smoothing FIR testbench
// Streams curves of varied length and content into the filter, predicts every
// smoothed sample from an independent sine-window model with edge replication,
// and compares the results in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sine_window_smoothing_fir_tb;
   import swsf_pkg::*;

   localparam int K_LEFT  = (TAPS - 1) / 2;
   localparam int K_RIGHT = TAPS - 1 - K_LEFT;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint ONE_Q16 = 65536;
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
   localparam int DRAIN_CYCLES = 20;

   logic    clock = 1'b0;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_item;
   logic    empty;
   logic    pop;
   rsp_type rsp_item;

   // Filter weights and curve state of the predictor.
   longint  win_weight [TAPS];
   longint  curve_win  [TAPS];
   int      curve_seen;
   bit      curve_open;
   rsp_type smoothed_due [$];

   int      errors;
   int      samples_sent;
   int      curves_sent;
   int      results_checked;
   int      full_stalls;
   bit      req_idle;
   bit      rsp_idle;
   int      rsp_hold_req;

   sine_window_smoothing_fir DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Sine of pi*m/d in Q30, odd Taylor series through the x^13 term.
   function automatic longint unsigned sine_q30(longint unsigned m, longint unsigned d);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (PI_Q30 * m) / d;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
         term = (term * x2) >> 30;
         term = term / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
      return longint'(acc);
   endfunction

   function automatic void build_weights();
      longint unsigned s [TAPS];
      longint unsigned total;
      longint          sum;
      int              m;
      total = 0;
      sum   = 0;
      if (TAPS <= 1) begin
         win_weight[0] = ONE_Q16;
         return;
      end
      for (int i = 0; i < TAPS; i++) begin
         m = (TAPS - 1 - i < i) ? TAPS - 1 - i : i;
         s[i] = sine_q30(m, TAPS - 1);
         total += s[i];
      end
      for (int i = 0; i < TAPS; i++) begin
         win_weight[i] = (total == 0) ? 0 : longint'((s[i] * ONE_Q16 + total / 2) / total);
         sum += win_weight[i];
      end
      // The rounding residue goes to the center tap so the weights sum to one.
      win_weight[K_LEFT] += ONE_Q16 - sum;
   endfunction

   // Output at edge offset e, with t earlier samples of the curve in the window.
   function automatic logic signed [SAMPLE_W-1:0] smoothed_at(int e, int t);
      longint acc;
      longint r;
      int     d;
      acc = 0;
      for (int j = 0; j < TAPS; j++) begin
         d = e + K_LEFT - j;
         if (d < 0) d = 0;
         if (d > t) d = t;
         if (d > TAPS - 1) d = TAPS - 1;
         acc += win_weight[j] * curve_win[d];
      end
      r = (acc + 32768) >>> 16;
      if (r > SAMPLE_MAX) r = SAMPLE_MAX;
      if (r < SAMPLE_MIN) r = SAMPLE_MIN;
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic void smooth_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      rsp_type r;
      int      t;
      int      e;
      t = curve_open ? curve_seen : 0;
      for (int i = TAPS - 1; i > 0; i--) curve_win[i] = curve_win[i-1];
      curve_win[0] = longint'(s);
      if (!last) begin
         if (t >= K_RIGHT) begin
            r.smoothed    = smoothed_at(K_RIGHT, t);
            r.is_last_res = 1'b0;
            smoothed_due.insert(smoothed_due.size(), r);
         end
         curve_open = 1'b1;
         curve_seen = (t + 1 > TAPS - 1) ? TAPS - 1 : t + 1;
      end else begin
         // The last sample flushes every output still owed for this curve.
         e = (t < K_RIGHT) ? t : K_RIGHT;
         for (; e >= 0; e--) begin
            r.smoothed    = smoothed_at(e, t);
            r.is_last_res = (e == 0);
            smoothed_due.insert(smoothed_due.size(), r);
         end
         curve_open = 1'b0;
         curve_seen = 0;
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      longint v;
      case ($urandom_range(0, 7))
         0: v = SAMPLE_MAX;
         1: v = SAMPLE_MIN;
         2: v = longint'($urandom_range(0, 32)) - 16;
         default: v = longint'($urandom);
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // Offers one item and returns at the edge where it is accepted.
   task automatic push_item(logic signed [SAMPLE_W-1:0] s, logic last);
      req_type r;
      int      gap;
      r.sample  = s;
      r.is_last = last;
      gap = req_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      forever begin
         @(posedge clock);
         if (!full) break;
         full_stalls++;
      end
      smooth_sample(s, last);
      samples_sent++;
      if (last) curves_sent++;
   endtask

   task automatic push_curve(int len);
      for (int i = 0; i < len; i++) push_item(pick_sample(), i == len - 1);
   endtask

   task automatic test_short_curves();
      push_item(SAMPLE_MAX[SAMPLE_W-1:0], 1'b1);
      push_item(SAMPLE_MIN[SAMPLE_W-1:0], 1'b0);
      push_item(SAMPLE_MAX[SAMPLE_W-1:0], 1'b1);
      push_curve(3);
      push_curve(K_RIGHT + 1);
   endtask

   // A long curve of alternating extremes, then a short one that must not see
   // the stale window entries it leaves behind.
   task automatic test_extremes_and_stale_window();
      for (int i = 0; i < 10; i++) begin
         push_item((i % 2 == 0) ? SAMPLE_MAX[SAMPLE_W-1:0] : SAMPLE_MIN[SAMPLE_W-1:0],
                   i == 9);
      end
      push_curve(4);
   endtask

   task automatic test_random_curves(int n_items);
      int sent;
      int len;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 9))
            0, 1, 2: len = $urandom_range(1, K_RIGHT + 1);
            9:       len = $urandom_range(21, 60);
            default: len = $urandom_range(K_RIGHT + 2, 20);
         endcase
         req_idle = ($urandom_range(0, 2) != 0);
         rsp_idle = ($urandom_range(0, 2) != 0);
         push_curve(len);
         sent += len;
      end
   endtask

   // The receiver holds off while the sender streams, so the block must stall.
   task automatic test_back_pressure();
      req_idle     = 1'b0;
      rsp_idle     = 1'b0;
      rsp_hold_req = 300;
      push_curve(25);
      push_curve(15);
   endtask

   task automatic test_full_rate();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      push_curve(17);
      push_curve(1);
      push_curve(2);
      push_curve(20);
   endtask

   task automatic wait_until_drained();
      int waited = 0;
      while (smoothed_due.size() != 0 && waited < 50_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (smoothed_due.size() != 0) begin
         errors++;
         $display("%0t: %0d smoothed samples never arrived", $time, smoothed_due.size());
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (smoothed_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, expected none, actual smoothed %0d last %0b",
                  $time, got.smoothed, got.is_last_res);
         return;
      end
      want = smoothed_due.pop_front();
      results_checked++;
      if (got.smoothed !== want.smoothed) begin
         errors++;
         $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                  $time, want.smoothed, got.smoothed);
      end
      if (got.is_last_res !== want.is_last_res) begin
         errors++;
         $display("%0t: is_last_res mismatch, expected %0b, actual %0b",
                  $time, want.is_last_res, got.is_last_res);
      end
   endtask

   initial begin : result_receiver
      int stall;
      int hold_left;
      stall     = 0;
      hold_left = 0;
      pop <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            check_result(rsp_item);
            stall = rsp_idle ? $urandom_range(0, 19) : 0;
         end
         if (rsp_hold_req > 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      errors          = 0;
      samples_sent    = 0;
      curves_sent     = 0;
      results_checked = 0;
      full_stalls     = 0;
      rsp_hold_req    = 0;
      req_idle        = 1'b1;
      rsp_idle        = 1'b1;
      build_weights();
      for (int i = 0; i < TAPS; i++) curve_win[i] = 0;
      curve_seen = 0;
      curve_open = 1'b0;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_item <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_short_curves();
      test_extremes_and_stale_window();
      test_random_curves(300);
      test_back_pressure();
      test_full_rate();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      test_random_curves(30);
      push <= 1'b0;
      wait_until_drained();

      $display("Sent %0d samples in %0d curves, checked %0d smoothed samples",
               samples_sent, curves_sent, results_checked);
      $display("Input was held off by a full block on %0d cycles", full_stalls);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
